// ----- rtl/tlcf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcf_pkg
// Shared types and constants of the text line to cell formatter.
// ----------------------------------------------------------------------------
package tlcf_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_SIZE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_ATTR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOLD_ATTR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDERLINE_ATTR = 3'd4;

    localparam logic [7:0] RST_LINE_WIDTH     = 8'd80;
    localparam logic [3:0] RST_TAB_SIZE       = 4'd4;
    localparam logic [7:0] RST_NORMAL_ATTR    = 8'h07;
    localparam logic [7:0] RST_BOLD_ATTR      = 8'h0f;
    localparam logic [7:0] RST_UNDERLINE_ATTR = 8'h0e;

    localparam logic [7:0] CH_BS         = 8'h08;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0a;
    localparam logic [7:0] CH_CR         = 8'h0d;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

    localparam logic EV_CELL_WRITE = 1'b0;
    localparam logic EV_LINE_DONE  = 1'b1;

    typedef struct packed {
        logic [7:0] line_width;
        logic [3:0] tab_size;
        logic [7:0] normal_attr;
        logic [7:0] bold_attr;
        logic [7:0] underline_attr;
    } tlcf_cfg_t;

    typedef struct packed {
        logic       event_res;
        logic [7:0] column;
        logic [7:0] glyph;
        logic [7:0] attribute;
        logic       last;
    } tlcf_res_t;

endpackage

// ----- rtl/tlcf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcf_in_if / tlcf_out_if
// Valid/ready channels for text bytes and cell results.
// ----------------------------------------------------------------------------
interface tlcf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface tlcf_out_if;
    logic       valid;
    logic       ready;
    logic       event_res;
    logic [7:0] column;
    logic [7:0] glyph;
    logic [7:0] attribute;
    logic       last;

    modport source (output valid, output event_res, output column, output glyph,
                    output attribute, output last, input ready);
    modport sink   (input valid, input event_res, input column, input glyph,
                    input attribute, input last, output ready);
endinterface

// ----- rtl/tlcf_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcf_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tlcf_cfg_regs
    import tlcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output tlcf_cfg_t             cfg
);

    tlcf_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width     <= RST_LINE_WIDTH;
            cfg_reg.tab_size       <= RST_TAB_SIZE;
            cfg_reg.normal_attr    <= RST_NORMAL_ATTR;
            cfg_reg.bold_attr      <= RST_BOLD_ATTR;
            cfg_reg.underline_attr <= RST_UNDERLINE_ATTR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_WIDTH:     cfg_reg.line_width     <= cfg_wdata;
                CFG_TAB_SIZE:       cfg_reg.tab_size       <= cfg_wdata[3:0];
                CFG_NORMAL_ATTR:    cfg_reg.normal_attr    <= cfg_wdata;
                CFG_BOLD_ATTR:      cfg_reg.bold_attr      <= cfg_wdata;
                CFG_UNDERLINE_ATTR: cfg_reg.underline_attr <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/tlcf_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcf_engine
// Input byte register, line state and per-cycle result generation.
// ----------------------------------------------------------------------------
module tlcf_engine
    import tlcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tlcf_cfg_t  cfg,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_ready,
    input  logic       slot_free,
    output logic       res_load,
    output tlcf_res_t  res
);

    logic       item_valid_reg;
    logic [7:0] byte_reg;
    logic [7:0] col_reg,      col_next;
    logic       pend_reg,     pend_next;
    logic [7:0] prev_reg,     prev_next;
    logic       tab_mode_reg, tab_mode_next;
    logic [3:0] tab_left_reg, tab_left_next;
    logic       cl_pend_reg,  cl_pend_next;

    logic       emit;
    logic       finish;
    logic       go;
    logic       do_tab;
    logic       do_done;
    logic [3:0] tab_left_cur;
    logic [3:0] tab_rem;
    logic [7:0] col_inc;

    assign col_inc = col_reg + 8'd1;
    assign tab_rem = tab_left_cur - 4'd1;

    always_comb
    begin
        res           = '0;
        emit          = 1'b0;
        finish        = 1'b0;
        do_tab        = 1'b0;
        do_done       = 1'b0;
        tab_left_cur  = tab_left_reg;
        col_next      = col_reg;
        pend_next     = pend_reg;
        prev_next     = prev_reg;
        tab_mode_next = tab_mode_reg;
        tab_left_next = tab_left_reg;
        cl_pend_next  = cl_pend_reg;

        if (item_valid_reg)
        begin
            if (cl_pend_reg)
            begin
                do_done = 1'b1;
            end
            else if (tab_mode_reg)
            begin
                do_tab = 1'b1;
            end
            else if (pend_reg)
            begin
                // overstrike: byte taken literally, dropped at column zero
                pend_next = 1'b0;
                finish    = 1'b1;
                if (col_reg != 8'd0)
                begin
                    emit          = 1'b1;
                    res.event_res = EV_CELL_WRITE;
                    res.column    = col_reg - 8'd1;
                    res.glyph     = byte_reg;
                    res.attribute = (prev_reg == CH_UNDERSCORE) ? cfg.underline_attr
                                                                : cfg.bold_attr;
                    res.last      = 1'b1;
                    prev_next     = byte_reg;
                end
            end
            else
            begin
                case (byte_reg)
                    CH_TAB:
                    begin
                        if (cfg.tab_size == 4'd0)
                            finish = 1'b1;
                        else if (col_reg >= cfg.line_width)
                            do_done = 1'b1;
                        else
                        begin
                            do_tab       = 1'b1;
                            tab_left_cur = cfg.tab_size;
                        end
                    end
                    CH_BS:
                    begin
                        pend_next = 1'b1;
                        finish    = 1'b1;
                    end
                    CH_CR:
                    begin
                        finish = 1'b1;
                    end
                    CH_LF:
                    begin
                        do_done = 1'b1;
                    end
                    default:
                    begin
                        emit          = 1'b1;
                        res.event_res = EV_CELL_WRITE;
                        res.column    = col_reg;
                        res.glyph     = byte_reg;
                        res.attribute = cfg.normal_attr;
                        col_next      = col_inc;
                        prev_next     = byte_reg;
                        // wrap of the column also ends the line
                        if (col_inc >= cfg.line_width || col_inc == 8'd0)
                            cl_pend_next = 1'b1;
                        else
                        begin
                            res.last = 1'b1;
                            finish   = 1'b1;
                        end
                    end
                endcase
            end

            // one blank cell of a tab; column is below the width here
            if (do_tab)
            begin
                emit          = 1'b1;
                res.event_res = EV_CELL_WRITE;
                res.column    = col_reg;
                res.glyph     = CH_SPACE;
                res.attribute = cfg.normal_attr;
                col_next      = col_inc;
                prev_next     = CH_SPACE;
                if (col_inc >= cfg.line_width)
                begin
                    cl_pend_next  = 1'b1;
                    tab_mode_next = 1'b0;
                end
                else if (tab_rem == 4'd0)
                begin
                    res.last      = 1'b1;
                    finish        = 1'b1;
                    tab_mode_next = 1'b0;
                end
                else
                begin
                    tab_mode_next = 1'b1;
                    tab_left_next = tab_rem;
                end
            end

            if (do_done)
            begin
                emit          = 1'b1;
                res.event_res = EV_LINE_DONE;
                res.last      = 1'b1;
                finish        = 1'b1;
                col_next      = 8'd0;
                pend_next     = 1'b0;
                prev_next     = CH_SPACE;
                cl_pend_next  = 1'b0;
            end
        end
    end

    assign go       = item_valid_reg && (!emit || slot_free);
    assign res_load = go && emit;
    assign in_ready = !item_valid_reg || (go && finish);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            col_reg        <= 8'd0;
            pend_reg       <= 1'b0;
            prev_reg       <= CH_SPACE;
            tab_mode_reg   <= 1'b0;
            tab_left_reg   <= 4'd0;
            cl_pend_reg    <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                item_valid_reg <= 1'b1;
            else if (go && finish)
                item_valid_reg <= 1'b0;

            if (go)
            begin
                col_reg      <= col_next;
                pend_reg     <= pend_next;
                prev_reg     <= prev_next;
                tab_mode_reg <= tab_mode_next;
                tab_left_reg <= tab_left_next;
                cl_pend_reg  <= cl_pend_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= in_byte;
    end

endmodule

// ----- rtl/tlcf_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcf_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module tlcf_out_reg
    import tlcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  tlcf_res_t  res,
    output logic       slot_free,
    output logic       valid,
    input  logic       ready,
    output tlcf_res_t  data
);

    logic      valid_reg;
    tlcf_res_t data_reg;

    assign slot_free = !valid_reg || ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- rtl/text_line_to_cell_formatter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_to_cell_formatter
// Turns a text byte stream into character/attribute cell writes per line.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one text byte per beat; out_ch carries one result per beat,
//   either a cell write (column, glyph, attribute) or a line-done marker.
//   last flags the final result caused by a byte. Bytes causing no result
//   (CR, backspace, overstrike at column zero, tab of size zero) give none.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// Timing:
//   A byte is registered on acceptance; its first result is then loaded into
//   the output register once that register is free, and out_ch shows it as
//   valid from that register.
//   Bytes giving one result or none sustain one byte per cycle while out_ch.ready
//   is high. A byte giving more than one result (tab cells, or a cell and a line-done)
//   holds the input until its last is loaded, one result a cycle while slot_free is high.
// Reset:
//   Clears column, overstrike and channel valids; registers take defaults.
// Stall:
//   While out_ch.ready is low the result is held and the input stops
//   once the engine has a result waiting.
// ----------------------------------------------------------------------------
module text_line_to_cell_formatter
    import tlcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tlcf_in_if.sink               in_ch,
    tlcf_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    tlcf_cfg_t cfg;
    tlcf_res_t res;
    tlcf_res_t out_data;
    logic      res_load;
    logic      slot_free;

    tlcf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tlcf_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_ch.valid),
        .in_byte   (in_ch.text_byte),
        .in_ready  (in_ch.ready),
        .slot_free (slot_free),
        .res_load  (res_load),
        .res       (res)
    );

    tlcf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .slot_free (slot_free),
        .valid     (out_ch.valid),
        .ready     (out_ch.ready),
        .data      (out_data)
    );

    assign out_ch.event_res = out_data.event_res;
    assign out_ch.column    = out_data.column;
    assign out_ch.glyph     = out_data.glyph;
    assign out_ch.attribute = out_data.attribute;
    assign out_ch.last      = out_data.last;

`ifndef SYNTHESIS
    // a line-done marker always closes the byte's results
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.event_res == EV_LINE_DONE |-> out_ch.last)
        else $error("line-done beat without last");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.event_res == EV_LINE_DONE |->
            out_ch.column == 8'd0 && out_ch.glyph == 8'd0 && out_ch.attribute == 8'd0)
        else $error("line-done beat with nonzero payload");

    // the line closes before the column can reach 255
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.event_res == EV_CELL_WRITE |-> out_ch.column != 8'hff)
        else $error("cell write past last column");
`endif

endmodule
